@@ rtl/bmhq_pkg.sv @@
// Shared types, constants and codes for the binary min-heap queue.
package bmhq_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int WORD_W = 32;

  // request operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // response status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_REMOVED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  // one heap entry: priority key and payload
  typedef struct packed {
    logic signed [WORD_W-1:0] key;
    logic signed [WORD_W-1:0] value;
  } entry_t;

  // heap memory access: two read ports, one write port
  typedef struct packed {
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } ram_req_t;

endpackage

@@ rtl/bmhq_if.sv @@
// Channel interfaces for requests, responses and the configuration write.
interface bmhq_req_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic signed [bmhq_pkg::WORD_W-1:0]  key;
  logic signed [bmhq_pkg::WORD_W-1:0]  value;
  modport source (output valid, op, key, value, input ready);
  modport sink   (input valid, op, key, value, output ready);
endinterface

interface bmhq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [bmhq_pkg::WORD_W-1:0]  result_value;
  logic [1:0]                          status;
  logic [bmhq_pkg::CNT_W-1:0]          occupancy;
  modport source (output valid, result_value, status, occupancy, input ready);
  modport sink   (input valid, result_value, status, occupancy, output ready);
endinterface

interface bmhq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bmhq_pkg::CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/bmhq_ram.sv @@
// Heap entry memory: one write port, two registered read ports.
module bmhq_ram (
  input  logic                clk,
  input  bmhq_pkg::ram_req_t  req,
  output bmhq_pkg::entry_t    rd_a_data,
  output bmhq_pkg::entry_t    rd_b_data
);

  bmhq_pkg::entry_t mem [bmhq_pkg::DEPTH];

  // write one entry
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // register both reads
  always_ff @(posedge clk) begin
    rd_a_data <= mem[req.rd_a_addr];
    rd_b_data <= mem[req.rd_b_addr];
  end

endmodule

@@ rtl/bmhq_ctrl.sv @@
// Heap sequencer: insert with sift-up, remove-min with sift-down, response register.
module bmhq_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bmhq_pkg::CNT_W-1:0]    capacity,
  bmhq_req_if.sink                      req,
  bmhq_rsp_if.source                    rsp,
  output bmhq_pkg::ram_req_t            ram_req,
  input  bmhq_pkg::entry_t              rd_a_data,
  input  bmhq_pkg::entry_t              rd_b_data
);

  localparam int ADDR_W = bmhq_pkg::ADDR_W;
  localparam int CNT_W  = bmhq_pkg::CNT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RM     = 3'd1;
  localparam logic [2:0] S_RD_UP  = 3'd2;
  localparam logic [2:0] S_CMP_UP = 3'd3;
  localparam logic [2:0] S_RD_DN  = 3'd4;
  localparam logic [2:0] S_CMP_DN = 3'd5;
  localparam logic [2:0] S_PUT    = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]                        state;
  logic [ADDR_W-1:0]                 pos;
  bmhq_pkg::entry_t                  mov;
  logic [CNT_W-1:0]                  count;
  logic signed [bmhq_pkg::WORD_W-1:0] res_value;
  logic [1:0]                        res_status;
  logic                              has_right;

  logic                 accept;
  logic [CNT_W-1:0]     limit;
  logic [ADDR_W-1:0]    parent;
  logic [ADDR_W:0]      left;
  logic [ADDR_W+1:0]    right;
  logic                 up_less;
  logic                 pick_right;
  bmhq_pkg::entry_t     pick_entry;
  logic [ADDR_W-1:0]    pick_idx;
  logic                 dn_swap;
  logic                 rsp_load;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign limit     = (capacity > CNT_W'(bmhq_pkg::DEPTH)) ? CNT_W'(bmhq_pkg::DEPTH) : capacity;

  // load the response register once it is free
  assign rsp_load  = (state == S_FIN) && (!rsp.valid || rsp.ready);

  // tree neighbors of the current hole
  assign parent = ADDR_W'((pos - 1'b1) >> 1);
  assign left   = {pos, 1'b1};
  assign right  = {1'b0, left} + 1'b1;

  // compare the moving entry against parent or smaller child
  assign up_less    = mov.key < rd_a_data.key;
  assign pick_right = has_right && (rd_b_data.key < rd_a_data.key);
  assign pick_entry = pick_right ? rd_b_data : rd_a_data;
  assign pick_idx   = pick_right ? right[ADDR_W-1:0] : left[ADDR_W-1:0];
  assign dn_swap    = pick_entry.key < mov.key;

  // drive memory reads and write-back
  always_comb begin
    ram_req.rd_a_addr = '0;
    ram_req.rd_b_addr = '0;
    ram_req.we        = 1'b0;
    ram_req.wr_addr   = pos;
    ram_req.wr_data   = mov;
    case (state)
      S_IDLE: begin
        if (accept && req.op == bmhq_pkg::OP_REMOVE) begin
          ram_req.rd_b_addr = ADDR_W'(count - 1'b1);
        end
      end
      S_RD_UP: begin
        ram_req.rd_a_addr = parent;
      end
      S_CMP_UP: begin
        ram_req.we = 1'b1;
        if (up_less) begin
          ram_req.wr_data = rd_a_data;
        end
      end
      S_RD_DN: begin
        ram_req.rd_a_addr = left[ADDR_W-1:0];
        ram_req.rd_b_addr = right[ADDR_W-1:0];
      end
      S_CMP_DN: begin
        ram_req.we = 1'b1;
        if (dn_swap) begin
          ram_req.wr_data = pick_entry;
        end
      end
      S_PUT: begin
        ram_req.we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequence one request and hold its response
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.op == bmhq_pkg::OP_INSERT) begin
              res_value <= '0;
              if (count >= limit) begin
                res_status <= bmhq_pkg::ST_DROPPED;
                state      <= S_FIN;
              end else begin
                res_status <= bmhq_pkg::ST_INSERTED;
                pos        <= count[ADDR_W-1:0];
                mov.key    <= req.key;
                mov.value  <= req.value;
                count      <= count + 1'b1;
                state      <= (count == '0) ? S_PUT : S_RD_UP;
              end
            end else begin
              if (count == '0) begin
                res_value  <= '1;
                res_status <= bmhq_pkg::ST_EMPTY;
                state      <= S_FIN;
              end else begin
                res_status <= bmhq_pkg::ST_REMOVED;
                count      <= count - 1'b1;
                state      <= S_RM;
              end
            end
          end
        end
        S_RM: begin
          res_value <= rd_a_data.value;
          mov       <= rd_b_data;
          pos       <= '0;
          state     <= (count == '0) ? S_FIN : S_RD_DN;
        end
        S_RD_UP: begin
          state <= S_CMP_UP;
        end
        S_CMP_UP: begin
          if (up_less) begin
            pos   <= parent;
            state <= (parent == '0) ? S_PUT : S_RD_UP;
          end else begin
            state <= S_FIN;
          end
        end
        S_RD_DN: begin
          if (left >= count) begin
            state <= S_PUT;
          end else begin
            has_right <= right < (ADDR_W+2)'(count);
            state     <= S_CMP_DN;
          end
        end
        S_CMP_DN: begin
          if (dn_swap) begin
            pos   <= pick_idx;
            state <= S_RD_DN;
          end else begin
            state <= S_FIN;
          end
        end
        S_PUT: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (rsp_load) begin
            rsp.result_value <= res_value;
            rsp.status       <= res_status;
            rsp.occupancy    <= count;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // count moves only when a request is taken
  a_count_at_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("entry count changed without a request");

  // the heap never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(bmhq_pkg::DEPTH))
    else $error("entry count above depth");

  // no memory write while waiting for a request or for the response register
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FIN) |-> !ram_req.we)
    else $error("memory written outside a sift");

  // a remove on a non-empty heap fetches root and last entry next
  a_remove_fetch: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == bmhq_pkg::OP_REMOVE && count != '0) |=> state == S_RM)
    else $error("remove did not fetch root");

endmodule

@@ rtl/binary_min_heap_queue_unit.sv @@
// Top level of the binary min-heap priority queue.
//
//  channel | dir | payload                              | request moved when
//  --------+-----+--------------------------------------+--------------------
//  req     | in  | op, key, value                       | req.valid & req.ready
//  rsp     | out | result_value, status, occupancy      | rsp.valid & rsp.ready
//  cfg     | in  | data (capacity)                      | cfg.valid & cfg.ready
//
// An insert rises level by level and ends with a write at the root or where it stops;
// a remove fetches root and last entry, then sinks level by level, and skips the sift
// when it empties the heap; a dropped insert or an empty remove only loads the response.
// Each level is one memory read and one compare with write-back.
// Reset is synchronous on rst; it empties the heap and sets capacity to 64.
// A stalled response does not block the port; the next request waits in its last step.
module binary_min_heap_queue_unit (
  input  logic        clk,
  input  logic        rst,
  bmhq_req_if.sink    req,
  bmhq_rsp_if.source  rsp,
  bmhq_cfg_if.sink    cfg
);

  logic [bmhq_pkg::CNT_W-1:0] capacity;
  bmhq_pkg::ram_req_t         ram_req;
  bmhq_pkg::entry_t           rd_a_data;
  bmhq_pkg::entry_t           rd_b_data;

  // hold the capacity register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bmhq_pkg::CAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      capacity <= cfg.data;
    end
  end

  bmhq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .req       (req),
    .rsp       (rsp),
    .ram_req   (ram_req),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  bmhq_ram u_ram (
    .clk       (clk),
    .req       (ram_req),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

endmodule
